// ===== design/pfd_pkg.sv =====
// package for the padded frame deframer
// types and constants shared by the parser, the result queue and the top level
// no dependencies
`default_nettype none

package pfd_pkg;

    localparam int LEN_W = 17;
    localparam int PLEN_W = 16;
    localparam int PRE_W = 12;

    // strategy codes above this force the old form
    localparam logic [3:0] STRATEGY_LIMIT = 4'd6;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    localparam logic [1:0] PATH_PASS = 2'd0;
    localparam logic [1:0] PATH_NEW  = 2'd1;
    localparam logic [1:0] PATH_OLD  = 2'd2;

    localparam logic [1:0] MODE_UNDECIDED = 2'd0;
    localparam logic [1:0] MODE_NEW       = 2'd1;
    localparam logic [1:0] MODE_OLD       = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       frame_empty;
        logic [1:0] path_code;
    } res_t;

    // up to two results from one input byte, first one in slot 0
    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } step_out_t;

endpackage

`default_nettype wire

// ===== design/pfd_parse.sv =====
// header parser and frame state for the padded frame deframer
// takes one registered byte per cycle with take high; up to two results
// depends on pfd_pkg
`default_nettype none

module pfd_parse
    import pfd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             take,
    input  wire logic [7:0]       data_byte,
    input  wire logic [LEN_W-1:0] frame_length,
    output step_out_t             step
);

    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [7:0]        hb0_reg, hb0_next;
    logic [7:0]        hb1_reg, hb1_next;
    logic [7:0]        held_reg, held_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [1:0]        mode_reg, mode_next;

    logic [LEN_W-1:0]  len;
    logic [LEN_W:0]    pos_inc;
    logic              last;
    logic [PRE_W-1:0]  pre;
    logic [LEN_W-1:0]  start;
    logic [LEN_W-1:0]  stop;
    logic [LEN_W-1:0]  old_start;
    logic [PLEN_W-1:0] plen_eff;
    logic [1:0]        mode_eff;
    logic              emit;
    logic              extra_v;
    logic              byte_v;
    logic              empty_v;
    res_t              extra_r;
    res_t              byte_r;
    res_t              empty_r;

    always_comb
    begin
        len = (frame_length == '0) ? LEN_W'(1) : frame_length;
        pos_inc = {1'b0, pos_reg} + (LEN_W+1)'(1);
        last = (pos_inc >= {1'b0, len});
        pre = {hb0_reg[3:0] & NIBBLE_MASK, hb1_reg};
        start = LEN_W'(pre) + LEN_W'(4);
        old_start = LEN_W'(pre) + LEN_W'(2);

        hb0_next = hb0_reg;
        hb1_next = hb1_reg;
        held_next = held_reg;
        plen_next = plen_reg;
        mode_eff = mode_reg;
        plen_eff = plen_reg;
        emit = 1'b0;
        extra_v = 1'b0;
        byte_v = 1'b0;
        empty_v = 1'b0;

        extra_r = '{out_byte: held_reg, out_last: 1'b0, frame_empty: 1'b0,
                    path_code: PATH_OLD};
        byte_r = '{out_byte: data_byte, out_last: 1'b0, frame_empty: 1'b0,
                   path_code: PATH_OLD};
        empty_r = '{out_byte: 8'd0, out_last: 1'b1, frame_empty: 1'b1,
                    path_code: PATH_OLD};
        stop = start + LEN_W'(plen_eff);

        if (len == LEN_W'(1))
        begin
            byte_v = 1'b1;
            byte_r.out_last = 1'b1;
            byte_r.path_code = PATH_PASS;
            mode_eff = MODE_UNDECIDED;
        end
        else
        begin
            if (pos_reg == LEN_W'(0))
            begin
                hb0_next = data_byte;
            end
            else if (pos_reg == LEN_W'(1))
            begin
                hb1_next = data_byte;
                mode_eff = (hb0_reg[7:4] <= STRATEGY_LIMIT && len >= LEN_W'(4))
                           ? MODE_UNDECIDED : MODE_OLD;
            end
            else
            begin
                emit = 1'b1;
                if (mode_reg == MODE_UNDECIDED)
                begin
                    if (pos_reg == LEN_W'(2))
                    begin
                        held_next = data_byte;
                        if (last)
                        begin
                            mode_eff = MODE_OLD;
                        end
                        else
                        begin
                            emit = 1'b0;
                        end
                    end
                    else
                    begin
                        plen_eff = {held_reg, data_byte};
                        plen_next = plen_eff;
                        stop = start + LEN_W'(plen_eff);
                        if (plen_eff != '0 && start < len && stop <= len)
                        begin
                            mode_eff = MODE_NEW;
                        end
                        else
                        begin
                            mode_eff = MODE_OLD;
                            // held byte 2 belongs to the old-form output
                            extra_v = (pre == '0);
                        end
                    end
                end
                if (emit)
                begin
                    if (mode_eff == MODE_NEW)
                    begin
                        if (pos_reg >= start && pos_reg < stop)
                        begin
                            byte_v = 1'b1;
                            byte_r.path_code = PATH_NEW;
                            byte_r.out_last = (pos_inc == {1'b0, stop});
                        end
                    end
                    else if (mode_eff == MODE_OLD)
                    begin
                        if (pos_reg >= old_start)
                        begin
                            byte_v = 1'b1;
                            byte_r.out_last = last;
                        end
                    end
                end
            end
            empty_v = last && !extra_v && !byte_v && (mode_eff == MODE_OLD);
        end

        if (last)
        begin
            pos_next = '0;
            mode_next = MODE_UNDECIDED;
        end
        else
        begin
            pos_next = pos_inc[LEN_W-1:0];
            mode_next = mode_eff;
        end

        step.v0 = take && (extra_v || byte_v || empty_v);
        step.v1 = take && extra_v && byte_v;
        step.r0 = extra_v ? extra_r : (byte_v ? byte_r : empty_r);
        step.r1 = byte_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hb0_reg <= '0;
            hb1_reg <= '0;
            held_reg <= '0;
            plen_reg <= '0;
            mode_reg <= MODE_UNDECIDED;
        end
        else if (take)
        begin
            pos_reg <= pos_next;
            hb0_reg <= hb0_next;
            hb1_reg <= hb1_next;
            held_reg <= held_next;
            plen_reg <= plen_next;
            mode_reg <= mode_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/pfd_out_fifo.sv =====
// four-entry result queue for the padded frame deframer
// takes up to two results a cycle and hands out one per transaction
// depends on pfd_pkg
`default_nettype none

module pfd_out_fifo
    import pfd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire step_out_t step,
    output logic           room,
    output logic           result_valid,
    input  wire logic      result_stall,
    output res_t           head
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    res_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             pop;
    logic [PTR_W-1:0] wr_plus;

    always_comb
    begin
        // a step may push two entries, so keep two free
        room = (cnt_reg <= (PTR_W+1)'(DEPTH - 2));
        result_valid = (cnt_reg != '0);
        head = mem_reg[rd_reg];
        pop = result_valid && !result_stall;
        wr_plus = wr_reg + PTR_W'(1);
        wr_next = wr_reg + PTR_W'(step.v0) + PTR_W'(step.v1);
        rd_next = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + (PTR_W+1)'(step.v0) + (PTR_W+1)'(step.v1)
                   - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (step.v0)
        begin
            mem_reg[wr_reg] <= step.r0;
        end
        if (step.v1)
        begin
            mem_reg[wr_plus] <= step.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/padded_frame_deframer.sv =====
// padded frame deframer: strips the control header and padding from a byte stream
// each accepted byte is registered, parsed, and its results pass via the result queue
// throughput: one byte per cycle; the input is held off only while the four-entry result
//   queue has fewer than two free places, which only a stalled output brings about
// reset: rst_n clears frame position, header state, mode and the result queue
// depends on pfd_pkg, pfd_parse and pfd_out_fifo
`default_nettype none

module padded_frame_deframer
    import pfd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire logic [7:0]       data_byte,
    input  wire logic [LEN_W-1:0] frame_length,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output logic [7:0]            out_byte,
    output logic                  out_last,
    output logic                  frame_empty,
    output logic [1:0]            path_code
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic [LEN_W-1:0] in_len_reg;
    logic             room;
    logic             take;
    step_out_t        step;
    res_t             head;

    // the held byte is processed once the queue can take two results
    assign take = in_valid_reg && room;
    assign item_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_byte_reg <= data_byte;
            in_len_reg <= frame_length;
        end
    end

    pfd_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .data_byte    (in_byte_reg),
        .frame_length (in_len_reg),
        .step         (step)
    );

    pfd_out_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    assign out_byte = head.out_byte;
    assign out_last = head.out_last;
    assign frame_empty = head.frame_empty;
    assign path_code = head.path_code;

endmodule

`default_nettype wire
